@@ sv/qws_pkg.sv @@
// Package for the quoted word splitter: scan modes, result kinds, special characters,
// register indexes, the result record and the escape mapping. No dependencies.
`default_nettype none

package qws_pkg;

  // Scan mode of the splitter
  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_SKIP   = 3'd1,
    MODE_DQ     = 3'd2,
    MODE_SQ     = 3'd3,
    MODE_DQ_ESC = 3'd4,
    MODE_SQ_ESC = 3'd5,
    MODE_ESC    = 3'd6,
    MODE_DONE   = 3'd7
  } qws_mode_t;

  // Result kind codes
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_WEND = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  // Special characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_F     = 8'h66;

  // Configuration register indexes
  localparam logic [1:0] REG_BREAK_A = 2'd0;
  localparam logic [1:0] REG_BREAK_B = 2'd1;
  localparam logic [1:0] REG_END_A   = 2'd2;
  localparam logic [1:0] REG_END_B   = 2'd3;

  // One result record as it leaves the block
  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  kind;
    logic [15:0] word_count;
    logic        last_of_run;
  } qws_result_t;

  // Map an escaped byte to its control code
  function automatic logic [7:0] esc_map(input logic [7:0] b);
    logic [7:0] r;
    unique case (b)
      CH_N:    r = 8'd10;
      CH_T:    r = 8'd9;
      CH_B:    r = 8'd8;
      CH_R:    r = 8'd13;
      CH_F:    r = 8'd12;
      default: r = b;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/qws_if.sv @@
// Stream interfaces for the quoted word splitter: byte input and result output.
// No dependencies.
`default_nettype none

interface qws_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface qws_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [1:0]  kind;
  logic [15:0] word_count;
  logic        last_of_run;

  modport source (output valid, output out_byte, output kind, output word_count,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input kind, input word_count,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

@@ sv/quoted_word_splitter.sv @@
// Quoted word splitter top level: scan state, APB register file and result queue.
// Depends on qws_pkg and the stream interfaces in qws_if.sv.
//
// Usage: bytes of a NUL-terminated string enter on in_ch, one per transaction.
// Each byte yields zero, one or two results on out_ch: word bytes, end-of-word
// markers and a string-finished marker, with last_of_run set on the final
// result of each byte. A NUL byte finishes the string and rearms the block.
// The user sets the break and end characters over the APB port (4 registers at byte
// addresses 0, 4, 8, 12) only while the block is idle; the block does not enforce this.
// Results enter the result queue as their byte is accepted and leave it in order.
// Throughput: one byte per cycle while out_ch takes results and each byte yields
// at most one result; a byte that yields two results holds the input back, since
// out_ch carries one result per cycle. The 4-entry result queue sets this: in_ch
// is ready while at least two entries are free.
// Reset: clears the scan state, word count and queue and loads the default
// break characters (space, tab) and end character (newline).
// Stall: when out_ch is held off, the queue fills and in_ch drops ready; no
// result is lost or repeated.
`default_nettype none

module quoted_word_splitter
  import qws_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  qws_in_if.sink           in_ch,
  qws_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Configuration registers
  logic [7:0] break_char_a, break_char_b, end_char_a, end_char_b;

  // Scan state
  qws_mode_t              scan_mode, scan_mode_next;
  logic                   word_has_bytes, word_has_bytes_next;
  logic [COUNT_WIDTH-1:0] words_so_far, words_so_far_next;

  // Result queue
  qws_result_t            queue_mem [DEPTH];
  logic [PTR_W-1:0]       wr_ptr, rd_ptr;
  logic [CNT_W-1:0]       fill;

  logic        in_fire, out_fire;
  logic [7:0]  b;
  logic        is_end_b, is_break_b;
  logic [1:0]  push_n;
  qws_result_t res0, res1;

  // Present the word count on 16 bits, saturating when wider
  function automatic logic [15:0] count_view(input logic [COUNT_WIDTH-1:0] c);
    logic [31:0] ext;
    ext = 32'(c);
    return (ext > 32'h0000_ffff) ? 16'hffff : ext[15:0];
  endfunction

  // APB register file
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      break_char_a <= 8'd32;
      break_char_b <= 8'd9;
      end_char_a   <= 8'd10;
      end_char_b   <= 8'd0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_BREAK_A: break_char_a <= pwdata[7:0];
        REG_BREAK_B: break_char_b <= pwdata[7:0];
        REG_END_A:   end_char_a   <= pwdata[7:0];
        REG_END_B:   end_char_b   <= pwdata[7:0];
        default:     break_char_a <= break_char_a;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_BREAK_A: prdata = {24'd0, break_char_a};
      REG_BREAK_B: prdata = {24'd0, break_char_b};
      REG_END_A:   prdata = {24'd0, end_char_a};
      REG_END_B:   prdata = {24'd0, end_char_b};
      default:     prdata = '0;
    endcase
  end

  // Handshakes
  assign in_ch.ready = (fill < CNT_W'(DEPTH - 1));
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_ch.valid = (fill != '0);
  assign out_fire    = out_ch.valid && out_ch.ready;

  // Character classes
  assign b          = in_ch.in_byte;
  assign is_end_b   = (b != CH_NUL) && (b == end_char_a || b == end_char_b);
  assign is_break_b = (b != CH_NUL) && (b == break_char_a || b == break_char_b);

  // Next scan state and the results of this byte
  always_comb begin
    logic                   do_finish, do_byte, do_wend, do_rearm;
    logic [7:0]             byte_val;
    logic [COUNT_WIDTH-1:0] cnt_inc;

    do_finish = 1'b0;
    do_byte   = 1'b0;
    do_wend   = 1'b0;
    do_rearm  = 1'b0;
    byte_val  = b;
    cnt_inc   = (words_so_far == '1) ? words_so_far : words_so_far + COUNT_WIDTH'(1);

    scan_mode_next      = scan_mode;
    word_has_bytes_next = word_has_bytes;
    words_so_far_next   = words_so_far;
    push_n = 2'd0;
    res0   = '0;
    res1   = '0;

    // classify the byte against the current mode
    unique case (scan_mode)
      MODE_DONE: begin
        if (b == CH_NUL) do_rearm = 1'b1;
      end
      MODE_ESC, MODE_DQ_ESC, MODE_SQ_ESC: begin
        if (b == CH_NUL) begin
          do_finish = 1'b1;
        end else begin
          do_byte  = 1'b1;
          byte_val = esc_map(b);
          unique case (scan_mode)
            MODE_ESC:    scan_mode_next = MODE_NORMAL;
            MODE_DQ_ESC: scan_mode_next = MODE_DQ;
            default:     scan_mode_next = MODE_SQ;
          endcase
        end
      end
      MODE_DQ, MODE_SQ: begin
        priority if (b == CH_NUL) begin
          do_finish = 1'b1;
        end else if (b == ((scan_mode == MODE_DQ) ? CH_DQ : CH_SQ)) begin
          scan_mode_next = MODE_NORMAL;
        end else if (is_end_b) begin
          do_finish = 1'b1;
        end else if (b == CH_BSL) begin
          scan_mode_next = (scan_mode == MODE_DQ) ? MODE_DQ_ESC : MODE_SQ_ESC;
        end else begin
          do_byte = 1'b1;
        end
      end
      default: begin
        priority if (b == CH_NUL || is_end_b) begin
          do_finish = 1'b1;
        end else if (is_break_b) begin
          do_wend        = (scan_mode != MODE_SKIP);
          scan_mode_next = MODE_SKIP;
        end else if (b == CH_DQ) begin
          scan_mode_next = MODE_DQ;
        end else if (b == CH_SQ) begin
          scan_mode_next = MODE_SQ;
        end else if (b == CH_BSL) begin
          scan_mode_next = MODE_ESC;
        end else begin
          scan_mode_next = MODE_NORMAL;
          do_byte        = 1'b1;
        end
      end
    endcase

    // build results and update the word state
    if (do_finish) begin
      if (word_has_bytes) begin
        res0   = '{out_byte: 8'd0, kind: KIND_WEND, word_count: count_view(cnt_inc),
                   last_of_run: 1'b0};
        res1   = '{out_byte: 8'd0, kind: KIND_DONE, word_count: count_view(cnt_inc),
                   last_of_run: 1'b1};
        push_n = 2'd2;
        words_so_far_next = cnt_inc;
      end else begin
        res0   = '{out_byte: 8'd0, kind: KIND_DONE, word_count: count_view(words_so_far),
                   last_of_run: 1'b1};
        push_n = 2'd1;
      end
      word_has_bytes_next = 1'b0;
      if (b == CH_NUL) begin
        scan_mode_next    = MODE_NORMAL;
        words_so_far_next = '0;
      end else begin
        scan_mode_next = MODE_DONE;
      end
    end else if (do_wend) begin
      res0   = '{out_byte: 8'd0, kind: KIND_WEND, word_count: count_view(cnt_inc),
                 last_of_run: 1'b1};
      push_n = 2'd1;
      words_so_far_next   = cnt_inc;
      word_has_bytes_next = 1'b0;
    end else if (do_byte) begin
      res0   = '{out_byte: byte_val, kind: KIND_BYTE,
                 word_count: count_view(words_so_far), last_of_run: 1'b1};
      push_n = 2'd1;
      word_has_bytes_next = 1'b1;
    end else if (do_rearm) begin
      scan_mode_next      = MODE_NORMAL;
      word_has_bytes_next = 1'b0;
      words_so_far_next   = '0;
    end
  end

  // Scan state register, advanced on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode      <= MODE_NORMAL;
      word_has_bytes <= 1'b0;
      words_so_far   <= '0;
    end else if (in_fire) begin
      scan_mode      <= scan_mode_next;
      word_has_bytes <= word_has_bytes_next;
      words_so_far   <= words_so_far_next;
    end
  end

  // Result queue pointers and fill level
  always_ff @(posedge clk) begin
    logic [1:0] add;
    add = in_fire ? push_n : 2'd0;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(add);
      if (out_fire) rd_ptr <= rd_ptr + PTR_W'(1);
      fill <= fill + CNT_W'(add) - CNT_W'(out_fire);
    end
  end

  // Result queue storage
  always_ff @(posedge clk) begin
    if (in_fire && push_n != 2'd0) queue_mem[wr_ptr] <= res0;
    if (in_fire && push_n == 2'd2) queue_mem[wr_ptr + PTR_W'(1)] <= res1;
  end

  // Drive the head of the queue
  assign out_ch.out_byte    = queue_mem[rd_ptr].out_byte;
  assign out_ch.kind        = queue_mem[rd_ptr].kind;
  assign out_ch.word_count  = queue_mem[rd_ptr].word_count;
  assign out_ch.last_of_run = queue_mem[rd_ptr].last_of_run;

  // Queue never overflows
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(DEPTH))
    else $error("result queue overfilled");

  // A string-finished marker always closes its byte's run
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.kind == KIND_DONE |-> out_ch.last_of_run)
    else $error("done marker without last_of_run");

  // A NUL byte rearms the scan state
  a_nul_rearm: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_ch.in_byte == CH_NUL |=>
      scan_mode == MODE_NORMAL && words_so_far == '0 && !word_has_bytes)
    else $error("NUL did not rearm the splitter");

  // Kind code stays in range on the output
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.kind != 2'd3)
    else $error("illegal result kind");

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for quoted_word_splitter: random and directed strings
// against a transaction-level predictor of the word splitting.
// Depends on qws_pkg, the stream interfaces in qws_if.sv and the block's RTL.
`default_nettype none

module tb_top;
  import qws_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          COUNT_BITS     = 16;
  localparam int unsigned WORD_MAX       = (1 << COUNT_BITS) - 1;
  localparam int          SETTLE_CYCLES  = 4;
  localparam int          TAIL_CYCLES    = 8;
  localparam int          HOLD_CYCLES    = 150;
  localparam int          WATCHDOG_LIMIT = 2000;

  localparam logic [7:0] ESC_LETTERS [5] = '{CH_N, CH_T, CH_B, CH_R, CH_F};

  // Predicts the result stream of the splitter and checks what comes out
  class qws_word_tracker;
    logic [7:0]   brk_a, brk_b, end_a, end_b;
    qws_mode_t    mode;
    bit           has_bytes;
    int unsigned  words;
    qws_result_t  expected_q[$];
    int           errors;

    function new();
      brk_a  = 8'd32;
      brk_b  = 8'd9;
      end_a  = 8'd10;
      end_b  = CH_NUL;
      errors = 0;
      rearm();
    endfunction

    function void set_reg(input logic [1:0] idx, input logic [7:0] v);
      case (idx)
        REG_BREAK_A: brk_a = v;
        REG_BREAK_B: brk_b = v;
        REG_END_A:   end_a = v;
        REG_END_B:   end_b = v;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void rearm();
      mode      = MODE_NORMAL;
      has_bytes = 1'b0;
      words     = 0;
    endfunction

    function bit is_end(input logic [7:0] b);
      return b != CH_NUL && (b == end_a || b == end_b);
    endfunction

    function bit is_break(input logic [7:0] b);
      return b != CH_NUL && (b == brk_a || b == brk_b);
    endfunction

    function logic [7:0] control_code(input logic [7:0] b);
      case (b)
        CH_N:    return 8'd10;
        CH_T:    return 8'd9;
        CH_B:    return 8'd8;
        CH_R:    return 8'd13;
        CH_F:    return 8'd12;
        default: return b;
      endcase
    endfunction

    function void emit(input logic [7:0] b, input logic [1:0] k);
      qws_result_t r;
      r.out_byte    = b;
      r.kind        = k;
      r.word_count  = words[15:0];
      r.last_of_run = 1'b0;
      expected_q.push_back(r);
    endfunction

    function void close_word();
      if (words < WORD_MAX) words++;
      has_bytes = 1'b0;
      emit(CH_NUL, KIND_WEND);
    endfunction

    function void add_byte(input logic [7:0] b);
      has_bytes = 1'b1;
      emit(b, KIND_BYTE);
    endfunction

    function void finish(input logic [7:0] b);
      if (has_bytes) close_word();
      emit(CH_NUL, KIND_DONE);
      if (b == CH_NUL) rearm();
      else mode = MODE_DONE;
    endfunction

    // Work out the results of one accepted input byte
    function void take_byte(input logic [7:0] b);
      int          start_n;
      logic [7:0]  quote;
      qws_result_t tail;
      start_n = expected_q.size();
      case (mode)
        MODE_DONE: begin
          if (b == CH_NUL) rearm();
        end
        MODE_ESC, MODE_DQ_ESC, MODE_SQ_ESC: begin
          if (b == CH_NUL) begin
            finish(b);
          end else begin
            add_byte(control_code(b));
            mode = (mode == MODE_ESC) ? MODE_NORMAL :
                   (mode == MODE_DQ_ESC) ? MODE_DQ : MODE_SQ;
          end
        end
        MODE_DQ, MODE_SQ: begin
          quote = (mode == MODE_DQ) ? CH_DQ : CH_SQ;
          if (b == CH_NUL) finish(b);
          else if (b == quote) mode = MODE_NORMAL;
          else if (is_end(b)) finish(b);
          else if (b == CH_BSL) mode = (mode == MODE_DQ) ? MODE_DQ_ESC : MODE_SQ_ESC;
          else add_byte(b);
        end
        default: begin
          if (b == CH_NUL || is_end(b)) begin
            finish(b);
          end else if (is_break(b)) begin
            if (mode != MODE_SKIP) close_word();
            mode = MODE_SKIP;
          end else begin
            mode = MODE_NORMAL;
            if (b == CH_DQ) mode = MODE_DQ;
            else if (b == CH_SQ) mode = MODE_SQ;
            else if (b == CH_BSL) mode = MODE_ESC;
            else add_byte(b);
          end
        end
      endcase
      // Flag the final result of this byte
      if (expected_q.size() > start_n) begin
        tail = expected_q.pop_back();
        tail.last_of_run = 1'b1;
        expected_q.push_back(tail);
      end
    endfunction

    function void check_result(input logic [7:0] ob, input logic [1:0] k,
                               input logic [15:0] wc, input logic lr);
      qws_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("unexpected result: kind %0d out_byte %0d word_count %0d", k, ob, wc);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (ob !== exp_r.out_byte) begin
        $error("out_byte mismatch: expected %0d, got %0d", exp_r.out_byte, ob);
        errors++;
      end
      if (k !== exp_r.kind) begin
        $error("kind mismatch: expected %0d, got %0d", exp_r.kind, k);
        errors++;
      end
      if (wc !== exp_r.word_count) begin
        $error("word_count mismatch: expected %0d, got %0d", exp_r.word_count, wc);
        errors++;
      end
      if (lr !== exp_r.last_of_run) begin
        $error("last_of_run mismatch: expected %0d, got %0d", exp_r.last_of_run, lr);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  wire  [31:0] prdata;
  wire         pready;

  int sender_idle_pct = 0;
  int stall_pct       = 0;
  bit hold_request    = 1'b0;
  int hold_left       = 0;
  int quiet_cycles    = 0;

  qws_word_tracker tracker = new();

  // Leading break, break runs, quotes, escapes, end byte, unterminated quotes
  logic [7:0] directed_bytes [27] = '{
    8'h20, "a", "b", 8'h09, 8'h20, "c", CH_DQ, 8'h20, CH_BSL, CH_N,
    CH_DQ, CH_SQ, CH_SQ, CH_BSL, CH_T, 8'hFF, CH_BSL, CH_NUL,
    CH_DQ, "q", 8'h0A, "z", CH_NUL, CH_SQ, CH_BSL, CH_R, CH_NUL
  };

  qws_in_if  in_ch ();
  qws_out_if out_ch ();

  quoted_word_splitter DUT (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk = ~clk;

  // Check each result transaction, then pick ready for the next cycle
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      tracker.check_result(out_ch.out_byte, out_ch.kind, out_ch.word_count,
                           out_ch.last_of_run);
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Stop the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one byte, idling first at random, and record it once accepted
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    tracker.take_byte(b);
  endtask

  // Drop valid and hold until every expected result has arrived
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    tracker.set_reg(idx, v);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] ba, input logic [7:0] bb,
                            input logic [7:0] ea, input logic [7:0] eb);
    wait_drained();
    write_reg(REG_BREAK_A, ba);
    write_reg(REG_BREAK_B, bb);
    write_reg(REG_END_A, ea);
    write_reg(REG_END_B, eb);
  endtask

  // Bias string bytes toward the characters the splitter reacts to
  function automatic logic [7:0] pick_string_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return tracker.brk_a;
    if (r < 18) return tracker.brk_b;
    if (r < 22) return $urandom_range(0, 1) ? tracker.end_a : tracker.end_b;
    if (r < 30) return CH_DQ;
    if (r < 36) return CH_SQ;
    if (r < 44) return CH_BSL;
    if (r < 52) return ESC_LETTERS[$urandom_range(0, 4)];
    if (r < 62) return 8'($urandom_range(1, 255));
    return 8'($urandom_range(8'h61, 8'h7a));
  endfunction

  // Send NUL-terminated strings, mostly shaped, some pure noise
  task automatic send_random_strings(input int n_bytes);
    int sent;
    int len;
    bit noise;
    sent = 0;
    while (sent < n_bytes) begin
      noise = ($urandom_range(0, 99) < 8);
      len   = noise ? $urandom_range(1, 8) : $urandom_range(0, 12);
      repeat (len) begin
        send_byte(noise ? 8'($urandom_range(0, 255)) : pick_string_byte());
        sent++;
      end
      send_byte(CH_NUL);
      sent++;
    end
  endtask

  initial begin
    rst           = 1'b1;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'd0;
    out_ch.ready  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = 4'd0;
    pwdata        = 32'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed strings under the reset settings, no idling
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

    // Comma and semicolon, end byte at the top of the range; sender idles
    set_config(",", 8'h00, ";", 8'hFF);
    sender_idle_pct = 55;
    send_random_strings(90);

    // Open a double quote, then make the quote an end byte: the quote closes
    send_byte(CH_NUL);
    send_byte(CH_DQ);
    send_byte("k");
    set_config(CH_BSL, 8'hFF, CH_DQ, 8'h01);
    sender_idle_pct = 0;
    stall_pct       = 55;
    send_byte(CH_DQ);
    send_random_strings(90);

    // No breaks or end bytes at all; both sides idle
    set_config(8'h00, 8'h00, 8'h00, 8'h00);
    sender_idle_pct = 16;
    stall_pct       = 16;
    send_random_strings(90);

    // Overlapping breaks and ends; long receiver hold while input keeps coming
    set_config(8'h20, CH_SQ, CH_SQ, 8'h20);
    sender_idle_pct = 0;
    stall_pct       = 0;
    hold_request    = 1'b1;
    send_random_strings(40);
    wait_drained();
    send_random_strings(50);

    // Back to the reset settings
    set_config(8'd32, 8'd9, 8'd10, 8'd0);
    sender_idle_pct = 16;
    stall_pct       = 16;
    send_random_strings(90);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
sv/qws_pkg.sv
sv/qws_if.sv
sv/quoted_word_splitter.sv
test/tb_top.sv
